>>> hdl/hsl2rgb_pkg.sv
// Shared types and constants for the HSL to RGB color converter pipeline.
// No dependencies; imported by every hsl2rgb module and by the top level.
`default_nettype none

package hsl2rgb_pkg;

   // Three input fields (hue, sat, lum) and three color channels (r, g, b)
   localparam int NumFields = 3;
   localparam int IdxHue    = 0;
   localparam int IdxSat    = 1;
   localparam int IdxLum    = 2;
   localparam int IdxRed    = 0;
   localparam int IdxGreen  = 1;
   localparam int IdxBlue   = 2;

   // Field widths
   localparam int InW     = 16;   // raw signed input
   localparam int FoldW   = 9;    // folded value, 0..360
   localparam int PctW    = 7;    // folded percent, 0..100
   localparam int QuotW   = 10;   // fold quotient estimate and first remainder
   localparam int RatioW  = 14;   // A1, A2 and their difference, 0..10000
   localparam int WeightW = 6;    // ramp weight, 0..60
   localparam int NumW    = 20;   // channel numerator, 0..600000
   localparam int ColorW  = 8;

   // Degree and percent limits
   localparam logic [FoldW-1:0] HueFull    = 9'd360;
   localparam logic [FoldW-1:0] HueThird   = 9'd120;
   localparam logic [FoldW-1:0] SegRiseEnd = 9'd60;
   localparam logic [FoldW-1:0] SegHoldEnd = 9'd180;
   localparam logic [FoldW-1:0] SegFallEnd = 9'd240;
   localparam logic [PctW-1:0]  PctMax     = 7'd100;
   localparam logic [PctW-1:0]  PctHalf    = 7'd50;
   localparam logic [NumW-1:0]  NumMax     = 20'd600000;

   // Fold: remainder by max via reciprocal multiply, one correction step
   localparam int FoldShift = 24;
   localparam int RecipW    = 18;
   localparam logic [FoldW-1:0] FoldMax [NumFields] =
      '{HueFull, FoldW'(PctMax), FoldW'(PctMax)};
   localparam logic [RecipW-1:0] FoldRecip [NumFields] =
      '{RecipW'((64'd1 << FoldShift) / HueFull),
        RecipW'((64'd1 << FoldShift) / PctMax),
        RecipW'((64'd1 << FoldShift) / PctMax)};

   // Scale: floor(255 * n / 600000) = floor(17 * n / 40000)
   localparam int ScaleMul    = 17;
   localparam int ScaleDiv    = 40000;
   localparam int ScaleShift  = 32;
   localparam int ScaleRecipW = 21;
   localparam int ScaledW     = 24;   // 17 * n
   localparam logic [ScaleRecipW-1:0] ScaleRecip =
      ScaleRecipW'(ScaleMul * ((64'd1 << ScaleShift) / ScaleDiv));

   // Pipeline control handed to each section
   typedef struct packed {
      logic adv;   // whole pipeline moves this cycle
      logic vld;   // beat entering the section is valid
   } stage_ctl_type;

   typedef logic [NumFields-1:0][InW-1:0]    field_vec_type;
   typedef logic [NumFields-1:0][FoldW-1:0]  fold_vec_type;
   typedef logic [NumFields-1:0][NumW-1:0]   num_vec_type;
   typedef logic [NumFields-1:0][ColorW-1:0] color_vec_type;

endpackage

`default_nettype wire

>>> hdl/hsl2rgb_fold.sv
// Range fold of hue, saturation and luminance: four register stages.
// Depends on hsl2rgb_pkg.
`default_nettype none

module hsl2rgb_fold
   import hsl2rgb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  stage_ctl_type ctl_in,
   input  field_vec_type din,
   output logic          vld_out,
   output fold_vec_type  fold_out
);

   localparam int ProdW = InW + RecipW;
   localparam int QmW   = QuotW + FoldW;

   logic [3:0] vld_in, vld_ff;

   // stage 1: magnitude and sign
   logic [NumFields-1:0][InW-1:0] mag1_in, mag1_ff;
   logic [NumFields-1:0]          neg1_in, neg1_ff;
   // stage 2: quotient estimate
   logic [NumFields-1:0][QuotW-1:0] q2_in, q2_ff;
   logic [NumFields-1:0][InW-1:0]   mag2_ff;
   logic [NumFields-1:0]            neg2_ff;
   // stage 3: first remainder and pass-through flags
   logic [NumFields-1:0][QuotW-1:0] r3_in, r3_ff;
   logic [NumFields-1:0][FoldW-1:0] small3_in, small3_ff;
   logic [NumFields-1:0]            le3_in, le3_ff;
   logic [NumFields-1:0]            zero3_in, zero3_ff;
   // stage 4: folded value
   logic [NumFields-1:0][FoldW-1:0] fold4_in, fold4_ff;

   assign vld_in = {vld_ff[2:0], ctl_in.vld};

   for (genvar f = 0; f < NumFields; f++) begin : g_field
      logic [ProdW-1:0] prod;
      logic [QmW-1:0]   qm;
      logic [QmW-1:0]   diff;
      logic [QuotW-1:0] max_q;

      always_comb begin
         // stage 1: absolute value (0x8000 stays 32768 unsigned)
         neg1_in[f] = din[f][InW-1];
         mag1_in[f] = din[f][InW-1] ? (~din[f] + InW'(1)) : din[f];

         // stage 2: q = floor(mag * recip / 2^shift), never above the true quotient
         prod     = ProdW'(mag1_ff[f]) * ProdW'(FoldRecip[f]);
         q2_in[f] = prod[FoldShift +: QuotW];

         // stage 3: remainder below twice the max
         qm           = QmW'(q2_ff[f]) * QmW'(FoldMax[f]);
         diff         = QmW'(mag2_ff[f]) - qm;
         r3_in[f]     = diff[QuotW-1:0];
         small3_in[f] = mag2_ff[f][FoldW-1:0];
         le3_in[f]    = mag2_ff[f] <= InW'(FoldMax[f]);
         zero3_in[f]  = neg2_ff[f] && (mag2_ff[f] == InW'(FoldMax[f]));

         // stage 4: select pass, minus-max zero, or corrected remainder
         max_q = QuotW'(FoldMax[f]);
         if (zero3_ff[f]) begin
            fold4_in[f] = '0;
         end else if (le3_ff[f]) begin
            fold4_in[f] = small3_ff[f];
         end else if (r3_ff[f] >= max_q) begin
            fold4_in[f] = FoldW'(r3_ff[f] - max_q);
         end else begin
            fold4_in[f] = FoldW'(r3_ff[f]);
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl_in.adv) begin
         vld_ff <= vld_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ctl_in.adv) begin
         mag1_ff   <= mag1_in;
         neg1_ff   <= neg1_in;
         q2_ff     <= q2_in;
         mag2_ff   <= mag1_ff;
         neg2_ff   <= neg1_ff;
         r3_ff     <= r3_in;
         small3_ff <= small3_in;
         le3_ff    <= le3_in;
         zero3_ff  <= zero3_in;
         fold4_ff  <= fold4_in;
      end
   end

   assign vld_out  = vld_ff[3];
   assign fold_out = fold4_ff;

endmodule

`default_nettype wire

>>> hdl/hsl2rgb_mix.sv
// HSL mixing terms A1, A2 and the per-channel ramp numerator: three stages.
// Depends on hsl2rgb_pkg.
`default_nettype none

module hsl2rgb_mix
   import hsl2rgb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  stage_ctl_type ctl_in,
   input  fold_vec_type  fold_in,
   output logic          vld_out,
   output num_vec_type   num_out
);

   localparam int WideW = 16;

   // ramp weight over one hue position: rise, hold, fall, floor
   function automatic logic [WeightW-1:0] seg_weight(input logic [FoldW-1:0] x);
      logic [FoldW-1:0] fall;
      logic [WeightW-1:0] w;
      fall = SegFallEnd - x;
      if (x < SegRiseEnd) begin
         w = WeightW'(x);
      end else if (x < SegHoldEnd) begin
         w = WeightW'(SegRiseEnd);
      end else if (x < SegFallEnd) begin
         w = WeightW'(fall);
      end else begin
         w = '0;
      end
      return w;
   endfunction

   logic [2:0] vld_in, vld_ff;

   logic [PctW-1:0]  sat, lum;
   logic [WideW-1:0] lo_a2, hi_a2, sl;
   logic [WideW-1:0] lum200, a2x2;
   logic [FoldW-1:0] x_red, x_grn, x_blu;

   // stage 5
   logic [RatioW-1:0] a2_5_in, a2_5_ff;
   logic [FoldW-1:0]  hue5_ff;
   logic [PctW-1:0]   lum5_ff;
   // stage 6
   logic [RatioW-1:0] a1_6_in, a1_6_ff;
   logic [RatioW-1:0] d6_in, d6_ff;
   logic [NumFields-1:0][WeightW-1:0] t6_in, t6_ff;
   // stage 7
   logic [NumFields-1:0][NumW-1:0] n7_in, n7_ff;

   assign vld_in = {vld_ff[1:0], ctl_in.vld};
   assign sat    = fold_in[IdxSat][PctW-1:0];
   assign lum    = fold_in[IdxLum][PctW-1:0];

   // stage 5: A2 = l(100+s) below half luminance, else 100(l+s) - sl
   always_comb begin
      lo_a2   = WideW'(lum) * (WideW'(sat) + WideW'(PctMax));
      sl      = WideW'(sat) * WideW'(lum);
      hi_a2   = WideW'(PctMax) * (WideW'(lum) + WideW'(sat)) - sl;
      a2_5_in = (lum < PctHalf) ? RatioW'(lo_a2) : RatioW'(hi_a2);
   end

   // stage 6: A1 = 200l - A2, slope A2 - A1, channel positions and weights
   always_comb begin
      lum200  = WideW'(lum5_ff) * WideW'(2 * PctMax);
      a2x2    = WideW'(a2_5_ff) + WideW'(a2_5_ff);
      a1_6_in = RatioW'(lum200 - WideW'(a2_5_ff));
      d6_in   = RatioW'(a2x2 - lum200);

      x_red = (hue5_ff > SegFallEnd) ? (hue5_ff - SegFallEnd) : (hue5_ff + HueThird);
      x_grn = hue5_ff;
      x_blu = (hue5_ff < HueThird) ? (hue5_ff + SegFallEnd) : (hue5_ff - HueThird);

      t6_in[IdxRed]   = seg_weight(x_red);
      t6_in[IdxGreen] = seg_weight(x_grn);
      t6_in[IdxBlue]  = seg_weight(x_blu);
   end

   // stage 7: n = 60*A1 + (A2-A1)*t
   for (genvar c = 0; c < NumFields; c++) begin : g_chan
      assign n7_in[c] = NumW'(a1_6_ff) * NumW'(SegRiseEnd)
                      + NumW'(d6_ff) * NumW'(t6_ff[c]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl_in.adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.adv) begin
         a2_5_ff <= a2_5_in;
         hue5_ff <= fold_in[IdxHue];
         lum5_ff <= lum;
         a1_6_ff <= a1_6_in;
         d6_ff   <= d6_in;
         t6_ff   <= t6_in;
         n7_ff   <= n7_in;
      end
   end

   assign vld_out = vld_ff[2];
   assign num_out = n7_ff;

endmodule

`default_nettype wire

>>> hdl/hsl2rgb_scale.sv
// Channel scaling floor(255 * n / 600000) in two stages; last stage is the
// output register. Depends on hsl2rgb_pkg.
`default_nettype none

module hsl2rgb_scale
   import hsl2rgb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  stage_ctl_type ctl_in,
   input  num_vec_type   num_in,
   output logic          vld_out,
   output color_vec_type color_out
);

   localparam int ProdW = NumW + ScaleRecipW;

   logic [1:0] vld_in, vld_ff;

   logic [NumFields-1:0][ScaledW-1:0] p8_in, p8_ff;
   logic [NumFields-1:0][ColorW-1:0]  q8_in, q8_ff;
   logic [NumFields-1:0][ColorW-1:0]  rgb9_in, rgb9_ff;

   assign vld_in = {vld_ff[0], ctl_in.vld};

   for (genvar c = 0; c < NumFields; c++) begin : g_chan
      logic [ProdW-1:0]   prod;
      logic [ScaledW-1:0] qd;
      logic [ScaledW-1:0] rem;

      always_comb begin
         // stage 8: quotient estimate, at most one below the true value
         prod     = ProdW'(num_in[c]) * ProdW'(ScaleRecip);
         q8_in[c] = prod[ScaleShift +: ColorW];
         p8_in[c] = ScaledW'(num_in[c]) * ScaledW'(ScaleMul);

         // stage 9: one correction step
         qd          = ScaledW'(q8_ff[c]) * ScaledW'(ScaleDiv);
         rem         = p8_ff[c] - qd;
         rgb9_in[c]  = (rem >= ScaledW'(ScaleDiv)) ? (q8_ff[c] + ColorW'(1)) : q8_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl_in.adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.adv) begin
         p8_ff   <= p8_in;
         q8_ff   <= q8_in;
         rgb9_ff <= rgb9_in;
      end
   end

   assign vld_out   = vld_ff[1];
   assign color_out = rgb9_ff;

endmodule

`default_nettype wire

>>> hdl/hsl_to_rgb_converter.sv
// HSL to RGB color converter, top level: fold, mix and scale sections.
// Depends on hsl2rgb_pkg, hsl2rgb_fold, hsl2rgb_mix, hsl2rgb_scale.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_hue_in, req_sat_in, req_lum_in
//   rsp      out        rsp_valid / rsp_ready  rsp_red, rsp_green, rsp_blue
//
// One beat per clock sustained; 9 register stages (4 fold, 3 mix, 2 scale).
// A beat accepted at a clock edge moves through the fold, mix and scale registers
// in order; rsp_valid rises once it reaches the output register.
// The scale section's last stage is the output register.
// While rsp_valid is high and rsp_ready low, the whole pipe holds and
// req_ready is low; otherwise a new beat is taken every cycle.
// Synchronous reset clears all valid bits; payload registers are not reset.
`default_nettype none

module hsl_to_rgb_converter
   import hsl2rgb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [InW-1:0]    req_hue_in,
   input  logic signed [InW-1:0]    req_sat_in,
   input  logic signed [InW-1:0]    req_lum_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic        [ColorW-1:0] rsp_red,
   output logic        [ColorW-1:0] rsp_green,
   output logic        [ColorW-1:0] rsp_blue
);

   logic          adv;
   stage_ctl_type fold_ctl, mix_ctl, scale_ctl;
   field_vec_type din;
   fold_vec_type  fold_val;
   num_vec_type   num_val;
   color_vec_type rgb;
   logic          fold_vld, mix_vld, scale_vld;

   // pipe moves unless a result is stuck at the output
   assign adv       = !scale_vld || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = scale_vld;

   assign din[IdxHue] = req_hue_in;
   assign din[IdxSat] = req_sat_in;
   assign din[IdxLum] = req_lum_in;

   assign fold_ctl  = '{adv: adv, vld: req_valid};
   assign mix_ctl   = '{adv: adv, vld: fold_vld};
   assign scale_ctl = '{adv: adv, vld: mix_vld};

   hsl2rgb_fold u_fold (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (fold_ctl),
      .din      (din),
      .vld_out  (fold_vld),
      .fold_out (fold_val)
   );

   hsl2rgb_mix u_mix (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (mix_ctl),
      .fold_in (fold_val),
      .vld_out (mix_vld),
      .num_out (num_val)
   );

   hsl2rgb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (scale_ctl),
      .num_in    (num_val),
      .vld_out   (scale_vld),
      .color_out (rgb)
   );

   assign rsp_red   = rgb[IdxRed];
   assign rsp_green = rgb[IdxGreen];
   assign rsp_blue  = rgb[IdxBlue];

   // folded fields stay within their ranges
   a_fold_range : assert property (@(posedge clock) disable iff (reset)
      fold_vld |-> (fold_val[IdxHue] <= HueFull)
                && (fold_val[IdxSat] <= FoldW'(PctMax))
                && (fold_val[IdxLum] <= FoldW'(PctMax)))
      else $error("folded field out of range");

   // ramp numerators never exceed full scale
   a_num_range : assert property (@(posedge clock) disable iff (reset)
      mix_vld |-> (num_val[IdxRed] <= NumMax)
               && (num_val[IdxGreen] <= NumMax)
               && (num_val[IdxBlue] <= NumMax))
      else $error("channel numerator above full scale");

   // a stalled pipe keeps the fold and mix section valid bits
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(fold_vld) && $stable(mix_vld))
      else $error("internal beat moved during stall");

endmodule

`default_nettype wire

>>> verif/rgb_checker.sv
// Checker for hsl_to_rgb_converter: predicts the color of every accepted request
// beat and compares it with the response beats in order. Depends on hsl2rgb_pkg.
`timescale 1ns / 1ps

module rgb_checker
   import hsl2rgb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic signed [InW-1:0] req_hue_in,
   input  logic signed [InW-1:0] req_sat_in,
   input  logic signed [InW-1:0] req_lum_in,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [ColorW-1:0]     rsp_red,
   input  logic [ColorW-1:0]     rsp_green,
   input  logic [ColorW-1:0]     rsp_blue,
   output int                    fail_count,
   output int                    pending_count
);

   typedef struct packed {
      logic [ColorW-1:0] red;
      logic [ColorW-1:0] green;
      logic [ColorW-1:0] blue;
   } pixel_rgb_type;

   pixel_rgb_type expected_rgb_q [$];

   // Fold a raw signed field into 0..maxv
   function automatic int fold_field(logic signed [InW-1:0] raw, int maxv);
      int v;
      v = raw;
      if (v >= 0 && v <= maxv) return v;
      if (v > maxv) return v % maxv;
      if (v > -maxv) return -v;
      if (v == -maxv) return 0;
      return (-v) % maxv;
   endfunction

   // One channel of the piecewise hue ramp, scaled to 8 bits
   function automatic logic [ColorW-1:0] ramp_channel(longint lo_level, longint hi_level,
                                                      int x);
      longint numer;
      if (x < 0) x += 360;
      if (x > 360) x -= 360;
      if (x < 60)       numer = 60 * lo_level + (hi_level - lo_level) * x;
      else if (x < 180) numer = 60 * hi_level;
      else if (x < 240) numer = 60 * lo_level + (hi_level - lo_level) * (240 - x);
      else              numer = 60 * lo_level;
      if (numer < 0) numer = 0;
      return ColorW'((255 * numer) / 600000);
   endfunction

   function automatic pixel_rgb_type predict_rgb(logic signed [InW-1:0] hue_raw,
                                                 logic signed [InW-1:0] sat_raw,
                                                 logic signed [InW-1:0] lum_raw);
      int            hue;
      int            sat;
      int            lum;
      longint        hi_level;
      longint        lo_level;
      pixel_rgb_type px;
      hue = fold_field(hue_raw, 360);
      sat = fold_field(sat_raw, 100);
      lum = fold_field(lum_raw, 100);
      // gray: no hue dependence
      if (sat == 0) begin
         px.red   = ColorW'((255 * lum) / 100);
         px.green = px.red;
         px.blue  = px.red;
         return px;
      end
      if (lum < 50) hi_level = longint'(lum) * (100 + sat);
      else          hi_level = 100 * longint'(lum + sat) - longint'(sat) * lum;
      lo_level = 200 * longint'(lum) - hi_level;
      px.red   = ramp_channel(lo_level, hi_level, hue + 120);
      px.green = ramp_channel(lo_level, hi_level, hue);
      px.blue  = ramp_channel(lo_level, hi_level, hue - 120);
      return px;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("rgb_checker: %0t mismatch on %s: got %0d, expected %0d",
               $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Response side is checked before the new request is queued
   always @(posedge clock) begin
      pixel_rgb_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rgb_q.size() == 0) begin
               report_mismatch("unexpected response beat", 1, 0);
            end else begin
               want = expected_rgb_q.pop_front();
               if (rsp_red !== want.red)     report_mismatch("red", rsp_red, want.red);
               if (rsp_green !== want.green) report_mismatch("green", rsp_green, want.green);
               if (rsp_blue !== want.blue)   report_mismatch("blue", rsp_blue, want.blue);
            end
         end
         if (req_valid && req_ready)
            expected_rgb_q.push_back(predict_rgb(req_hue_in, req_sat_in, req_lum_in));
         pending_count = expected_rgb_q.size();
      end
   end

endmodule

>>> verif/tb.sv
// Testbench top for hsl_to_rgb_converter: clock, reset, directed and random
// request beats, response back-pressure and verdict. Depends on rgb_checker.
`timescale 1ns / 1ps

module tb
   import hsl2rgb_pkg::*;
();

   localparam int RandomPixels  = 1725;
   localparam int QuietTail     = 250;
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 20;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic signed [InW-1:0] req_hue_in;
   logic signed [InW-1:0] req_sat_in;
   logic signed [InW-1:0] req_lum_in;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [ColorW-1:0]     rsp_red;
   logic [ColorW-1:0]     rsp_green;
   logic [ColorW-1:0]     rsp_blue;

   int fail_count;
   int pending_count;
   int idle_cycles;
   bit idle_on;
   int rsp_hold;

   hsl_to_rgb_converter u_top (.*);

   rgb_checker u_checker (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: cycles in which no beat moves on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // Response back-pressure in random bursts
   initial begin
      rsp_ready = 1'b0;
      rsp_hold  = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ready <= !reset;
            if (!reset && idle_on && $urandom_range(5) == 0)
               rsp_hold = $urandom_range(9, 1);
         end
      end
   end

   // Drive one request beat, with an optional idle burst ahead of it
   task automatic send_pixel(logic signed [InW-1:0] hue, logic signed [InW-1:0] sat,
                             logic signed [InW-1:0] lum);
      int gap;
      gap = (idle_on && $urandom_range(3) == 0) ? $urandom_range(9, 1) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_hue_in <= hue;
      req_sat_in <= sat;
      req_lum_in <= lum;
      req_valid  <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Hold the sender until every outstanding color has come back
   task automatic drain_pipe();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Field value: mostly in range, with negatives, overflow and raw 16-bit noise
   function automatic logic signed [InW-1:0] pick_field(int maxv);
      int sel;
      sel = $urandom_range(19);
      if (sel < 9)  return InW'($urandom_range(maxv));
      if (sel < 12) return InW'(-int'($urandom_range(maxv, 1)));
      if (sel < 14) return InW'(maxv + int'($urandom_range(2 * maxv, 1)));
      if (sel < 15) return InW'(-maxv - int'($urandom_range(2 * maxv, 1)));
      if (sel < 16) begin
         case ($urandom_range(5))
            0: return InW'(maxv);
            1: return InW'(-maxv);
            2: return InW'(2 * maxv);
            3: return InW'(-2 * maxv);
            4: return 16'sh7fff;
            default: return 16'sh8000;
         endcase
      end
      if (sel < 17) return '0;
      return InW'($urandom_range(16'hffff));
   endfunction

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_hue_in = '0;
      req_sat_in = '0;
      req_lum_in = '0;
      idle_on    = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, fold cases, hue segments, gray and lightness split
      send_pixel(0, 0, 0);
      send_pixel(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_pixel(16'sh8000, 16'sh8000, 16'sh8000);
      send_pixel(-360, -100, -100);
      send_pixel(720, 200, 200);
      send_pixel(360, 100, 50);
      send_pixel(0, 100, 50);
      send_pixel(60, 100, 50);
      send_pixel(120, 100, 50);
      send_pixel(180, 100, 50);
      send_pixel(240, 100, 50);
      send_pixel(300, 100, 50);
      send_pixel(359, 99, 99);
      send_pixel(361, 101, 101);
      send_pixel(-361, -101, -101);
      send_pixel(-200, -30, -40);
      send_pixel(-1, -1, -1);
      send_pixel(200, 0, 73);
      send_pixel(45, 0, 100);
      send_pixel(30, 50, 49);
      send_pixel(30, 50, 50);
      send_pixel(90, 100, 100);
      send_pixel(210, 75, 25);
      send_pixel(330, 100, 0);
      drain_pipe();

      // Random part; the tail runs without idling on either side
      for (int i = 0; i < RandomPixels; i++) begin
         if (i % 200 == 0) idle_on = ($urandom_range(2) != 0);
         if (i == RandomPixels / 2) drain_pipe();
         if (i >= RandomPixels - QuietTail) idle_on = 1'b0;
         send_pixel(pick_field(360), pick_field(100), pick_field(100));
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (fail_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
